[design/asb_pkg.sv]
`default_nettype none

package asb_pkg;

    // fixed-point layout
    localparam int FRAC_BITS   = 16;
    localparam int SAT_W       = 32;
    localparam int HIST_W      = 8;
    localparam int PHASE_W     = 16;
    localparam int CNT_W       = 4;
    localparam int MAJORITY_MIN = 5;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_DATA_W-1:0] DECAY_RESET = 16'd102;
    localparam logic [CFG_DATA_W-1:0] STEP_RESET  = 16'd3277;

    // bit clock nudge toward mid-bit
    localparam logic [PHASE_W-1:0] PHASE_NUDGE = 16'h0800;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECAY    = 2'd0,
        REG_POLARITY = 2'd1,
        REG_STEP     = 2'd2
    } asb_reg_t;

    // from the top level to the bit clock
    typedef struct packed {
        logic advance;
        logic slice_bit;
    } asb_step_t;

    // from the bit clock back to the top level
    typedef struct packed {
        logic emit;
        logic bit_res;
    } asb_result_t;

endpackage

`default_nettype wire

[design/asb_sample_if.sv]
`default_nettype none

interface asb_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[design/asb_bit_if.sv]
`default_nettype none

interface asb_bit_if;
    logic valid;
    logic ready;
    logic bit_res;

    modport source (output valid, output bit_res, input ready);
    modport sink   (input valid, input bit_res, output ready);
endinterface

`default_nettype wire

[design/asb_peak_track.sv]
`default_nettype none

module asb_peak_track #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DECAY_BITS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 advance,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  wire logic [asb_pkg::CFG_DATA_W-1:0]       decay_fraction,
    input  wire logic                                 polarity_invert,
    output logic                                      slice_bit
);

    localparam int PEAK_W = (SAMPLE_WIDTH + asb_pkg::FRAC_BITS > asb_pkg::SAT_W) ?
                            SAMPLE_WIDTH + asb_pkg::FRAC_BITS : asb_pkg::SAT_W;
    localparam int PROD_W = PEAK_W + asb_pkg::CFG_DATA_W + 2;
    localparam int CAND_W = PROD_W + 1;

    localparam logic signed [CAND_W-1:0] SAT_HI = CAND_W'(32'sh7FFF_FFFF);
    localparam logic signed [CAND_W-1:0] SAT_LO = CAND_W'(32'sh8000_0000);

    logic signed [PEAK_W-1:0]                upper_reg;
    logic signed [PEAK_W-1:0]                lower_reg;
    logic signed [PEAK_W-1:0]                upper_next;
    logic signed [PEAK_W-1:0]                lower_next;
    logic signed [PEAK_W-1:0]                x;
    logic signed [PEAK_W:0]                  range_w;
    logic signed [asb_pkg::CFG_DATA_W:0]     decay_s;
    logic signed [PROD_W-1:0]                prod;
    logic signed [PROD_W-1:0]                delta;
    logic signed [CAND_W-1:0]                up_cand;
    logic signed [CAND_W-1:0]                lo_cand;
    logic signed [PEAK_W+1:0]                twice_x;
    logic signed [PEAK_W+1:0]                peak_sum;

    function automatic logic signed [CAND_W-1:0] sat32(input logic signed [CAND_W-1:0] v);
        logic signed [CAND_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        else
            r = v;
        return r;
    endfunction

    // sample in Q16.16 and decay step taken from the old range
    always_comb
    begin
        x        = PEAK_W'(sample) <<< asb_pkg::FRAC_BITS;
        range_w  = (PEAK_W+1)'(upper_reg) - (PEAK_W+1)'(lower_reg);
        decay_s  = $signed({1'b0, decay_fraction});
        prod     = PROD_W'(range_w) * PROD_W'(decay_s);
        delta    = prod >>> DECAY_BITS;
        up_cand  = CAND_W'(upper_reg) - CAND_W'(delta);
        lo_cand  = CAND_W'(lower_reg) + CAND_W'(delta);
    end

    // peaks follow the sample or relax toward each other
    always_comb
    begin
        if (x > upper_reg)
            upper_next = x;
        else
            upper_next = PEAK_W'(sat32(up_cand));
        if (x < lower_reg)
            lower_next = x;
        else
            lower_next = PEAK_W'(sat32(lo_cand));
    end

    // exact slice against the midpoint of the updated peaks
    always_comb
    begin
        twice_x  = (PEAK_W+2)'(x) <<< 1;
        peak_sum = (PEAK_W+2)'(upper_next) + (PEAK_W+2)'(lower_next);
        if (polarity_invert)
            slice_bit = (twice_x > peak_sum);
        else
            slice_bit = (twice_x < peak_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else if (advance)
        begin
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

endmodule

`default_nettype wire

[design/asb_bit_clock.sv]
`default_nettype none

module asb_bit_clock (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire asb_pkg::asb_step_t               step,
    input  wire logic [asb_pkg::PHASE_W-1:0]      phase_step,
    output asb_pkg::asb_result_t                  result
);

    logic [asb_pkg::HIST_W-1:0]  hist_reg;
    logic [asb_pkg::HIST_W-1:0]  hist_next;
    logic [asb_pkg::PHASE_W-1:0] phase_reg;
    logic [asb_pkg::PHASE_W-1:0] phase_nudged;
    logic [asb_pkg::PHASE_W:0]   phase_sum;
    logic                        clean_edge;
    logic [asb_pkg::CNT_W-1:0]   ones;

    // history shift and clean-pair detection (0011, 1100, 0110, 1001)
    always_comb
    begin
        hist_next  = {hist_reg[asb_pkg::HIST_W-2:0], step.slice_bit};
        clean_edge = (hist_next[2] ^ hist_next[0]) & (hist_next[3] ^ hist_next[1]);
    end

    // pull the phase toward mid-bit, then advance it
    always_comb
    begin
        phase_nudged = phase_reg;
        if (clean_edge)
        begin
            if (!phase_reg[asb_pkg::PHASE_W-1])
                phase_nudged = phase_reg + asb_pkg::PHASE_NUDGE;
            else
                phase_nudged = phase_reg - asb_pkg::PHASE_NUDGE;
        end
        phase_sum = {1'b0, phase_nudged} + {1'b0, phase_step};
    end

    // majority vote over the last eight decisions
    always_comb
    begin
        ones = '0;
        for (int i = 0; i < asb_pkg::HIST_W; i++)
            ones = ones + asb_pkg::CNT_W'(hist_next[i]);
        result.emit    = phase_sum[asb_pkg::PHASE_W];
        result.bit_res = (ones >= asb_pkg::CNT_W'(asb_pkg::MAJORITY_MIN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            phase_reg <= '0;
        end
        else if (step.advance)
        begin
            hist_reg  <= hist_next;
            phase_reg <= phase_sum[asb_pkg::PHASE_W-1:0];
        end
    end

endmodule

`default_nettype wire

[design/afsk_slicer_bit_clock_core.sv]
`default_nettype none

// AFSK slicer and bit clock recovery. Takes one filtered correlator sample per
// transaction on sample_ch and accepts a new sample every clock cycle unless
// bit_ch stalls. Each sample is held in an input register and processed once
// the output register can take a result: the peak trackers, slicer,
// eight-decision history and 16-bit bit clock are updated together, and a
// recovered bit, when the clock wraps, lands in the output register on bit_ch
// with them. The sustained rate of one sample per cycle is set by the
// peak-tracker loop (decay multiply, saturating add) closing combinationally.
// sample_ch stays ready while the output register is empty or being drained;
// with a result waiting, one further sample is held in the input register.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are meant for idle periods; index 0 is the decay fraction, 1 the polarity
// and 2 the phase step, and other indexes are ignored.

module afsk_slicer_bit_clock_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DECAY_BITS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    asb_sample_if.sink                                sample_ch,
    asb_bit_if.source                                 bit_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [asb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [asb_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [asb_pkg::CFG_DATA_W-1:0]  decay_reg;
    logic                            polarity_reg;
    logic [asb_pkg::PHASE_W-1:0]     step_reg;

    logic                            in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_reg;
    logic                            out_valid_reg;
    logic                            out_bit_reg;

    logic                            advance;
    logic                            slice_bit;
    asb_pkg::asb_step_t              step;
    asb_pkg::asb_result_t            result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg    <= asb_pkg::DECAY_RESET;
            polarity_reg <= 1'b0;
            step_reg     <= asb_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (asb_pkg::asb_reg_t'(cfg_index))
                asb_pkg::REG_DECAY:    decay_reg    <= cfg_data;
                asb_pkg::REG_POLARITY: polarity_reg <= cfg_data[0];
                asb_pkg::REG_STEP:     step_reg     <= cfg_data[asb_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // the held sample moves on when the output register can take a result
    assign advance         = in_valid_reg && (!out_valid_reg || bit_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample_ch.ready)
            in_valid_reg <= sample_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
            sample_reg <= sample_ch.sample;
    end

    asb_peak_track #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DECAY_BITS   (DECAY_BITS)
    ) u_peak (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .sample          (sample_reg),
        .decay_fraction  (decay_reg),
        .polarity_invert (polarity_reg),
        .slice_bit       (slice_bit)
    );

    assign step = '{advance: advance, slice_bit: slice_bit};

    asb_bit_clock u_clock (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .phase_step (step_reg),
        .result     (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= result.emit;
        else if (bit_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
            out_bit_reg <= result.bit_res;
    end

    assign bit_ch.valid   = out_valid_reg;
    assign bit_ch.bit_res = out_bit_reg;

endmodule

`default_nettype wire

[design/asb_checker.sv]
`default_nettype none

module asb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_bit
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bit))
        else $error("stalled result changed");

    // samples are taken whenever the output side is free or draining
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("sample channel stalled with output free");

    // backpressure on samples only builds up from a sample just taken
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("sample channel stalled without a held sample");

    // nothing comes out straight after reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result presented right after reset");

endmodule

bind afsk_slicer_bit_clock_core asb_checker u_asb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (bit_ch.valid),
    .out_ready (bit_ch.ready),
    .out_bit   (bit_ch.bit_res)
);

`default_nettype wire

[bench/afsk_slicer_bit_clock_core_test.sv]
`timescale 1ns / 100ps

module afsk_slicer_bit_clock_core_test;

    localparam int SMP_W         = 16;
    localparam int DECAY_SHIFT   = 16;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 4;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1500;
    localparam longint PEAK_HI   = 64'sd2147483647;
    localparam longint PEAK_LO   = -64'sd2147483648;

    // index that no register answers to
    localparam logic [asb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // how a directed row gets its expected bit
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_ZERO
    } bit_exp_t;

    typedef struct {
        row_kind_t                       kind;
        logic [asb_pkg::CFG_INDEX_W-1:0] idx;
        logic [15:0]                     value;
        bit_exp_t                        want;
    } stim_row_t;

    typedef struct packed {
        logic emit;
        logic data_bit;
    } bit_pred_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [asb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [asb_pkg::CFG_DATA_W-1:0]  cfg_data;

    asb_sample_if #(.SAMPLE_WIDTH(SMP_W)) smp_if ();
    asb_bit_if bit_if ();

    afsk_slicer_bit_clock_core #(
        .SAMPLE_WIDTH (SMP_W),
        .DECAY_BITS   (DECAY_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_if),
        .bit_ch    (bit_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the slicer state and its settings
    longint      peak_hi = 0;
    longint      peak_lo = 0;
    logic [7:0]  slice_hist = '0;
    logic [15:0] clk_phase = '0;
    logic [15:0] decay_cfg = asb_pkg::DECAY_RESET;
    logic [15:0] step_cfg = asb_pkg::STEP_RESET;
    logic        pol_cfg = 1'b0;

    logic      expected_bits[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    bit        tx_quiet = 1'b0;
    bit        rx_quiet = 1'b0;
    bit        rx_hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // append one row to the directed table
    function automatic void add_row(input row_kind_t row_kind,
                                    input logic [asb_pkg::CFG_INDEX_W-1:0] row_idx,
                                    input logic [15:0] row_value,
                                    input bit_exp_t row_want);
        stim_row_t row;
        row = '{row_kind, row_idx, row_value, row_want};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic longint clip_q16(input longint v);
        if (v > PEAK_HI)
            return PEAK_HI;
        if (v < PEAK_LO)
            return PEAK_LO;
        return v;
    endfunction

    // peak tracking, slicing and bit clock for one sample
    function automatic bit_pred_t recover_bit(input logic signed [SMP_W-1:0] smp);
        longint     x;
        longint     span;
        longint     relax;
        longint     centre_sum;
        logic       slice;
        logic [16:0] phase_sum;
        bit_pred_t  r;
        x = longint'(smp) * (64'sd1 <<< asb_pkg::FRAC_BITS);
        span = peak_hi - peak_lo;
        relax = (span * longint'(decay_cfg)) >>> DECAY_SHIFT;
        if (x > peak_hi)
            peak_hi = x;
        else
            peak_hi = clip_q16(peak_hi - relax);
        if (x < peak_lo)
            peak_lo = x;
        else
            peak_lo = clip_q16(peak_lo + relax);
        // exact centre compare, a tie slices as zero
        centre_sum = peak_hi + peak_lo;
        if (pol_cfg)
            slice = (2 * x > centre_sum);
        else
            slice = (2 * x < centre_sum);
        slice_hist = {slice_hist[6:0], slice};
        // clean transition pair pulls the clock toward mid-bit
        if ((slice_hist[1:0] ^ slice_hist[3:2]) == 2'b11)
        begin
            if (clk_phase < 16'h8000)
                clk_phase = clk_phase + asb_pkg::PHASE_NUDGE;
            else
                clk_phase = clk_phase - asb_pkg::PHASE_NUDGE;
        end
        phase_sum = {1'b0, clk_phase} + {1'b0, step_cfg};
        clk_phase = phase_sum[15:0];
        r.emit = phase_sum[16];
        r.data_bit = ($countones(slice_hist) >= asb_pkg::MAJORITY_MIN);
        return r;
    endfunction

    // offer one sample and log what it should produce once taken
    task automatic send_sample(input logic [15:0] smp, input bit_exp_t want);
        int        gap;
        bit_pred_t p;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample <= smp;
        do
            @(posedge clk);
        while (!smp_if.ready);
        p = recover_bit(smp);
        case (want)
            EXP_MODEL:
            begin
                if (p.emit)
                    expected_bits.insert(expected_bits.size(), p.data_bit);
            end
            EXP_ZERO: expected_bits.insert(expected_bits.size(), 1'b0);
            default: ;
        endcase
    endtask

    // settings change only once the block has gone quiet
    task automatic write_register(input logic [asb_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] data);
        smp_if.valid <= 1'b0;
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            asb_pkg::REG_DECAY: decay_cfg = data;
            asb_pkg::REG_POLARITY: pol_cfg = data[0];
            asb_pkg::REG_STEP: step_cfg = data;
            default: ;
        endcase
    endtask

    // receiver: random back-pressure, plus one long hold when asked
    initial
    begin
        int stall;
        bit_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                stall = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            else
                stall = rx_quiet ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                bit_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            bit_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!bit_if.valid);
        end
    end

    // compare each bit transaction with the oldest expected bit
    always @(posedge clk)
    begin : bit_check
        logic want;
        if (rst_n && bit_if.valid && bit_if.ready)
        begin
            if (expected_bits.size() == 0)
                report_mismatch($sformatf("bit %0b with nothing expected", bit_if.bit_res));
            else
            begin
                want = expected_bits.pop_front();
                if (bit_if.bit_res !== want)
                    report_mismatch($sformatf("bit %0b, expected %0b", bit_if.bit_res, want));
            end
        end
    end

    initial
    begin
        int          random_sent;
        int          phase_len;
        int          phase_no;
        int          spb;
        int          amp;
        int          bias;
        int          level;
        int          run_left;
        int          value;
        int          n;
        logic [15:0] step_pick;
        logic [15:0] decay_pick;

        smp_if.valid <= 1'b0;
        smp_if.sample <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rst_n <= 1'b0;

        // directed rows: reset state, extremes, masking, crossing peaks, zero settings
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0000, EXP_NONE);
        add_row(ROW_WRITE,  asb_pkg::REG_STEP,     16'hFFFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0000, EXP_ZERO);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0000, EXP_ZERO);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_ZERO);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_ZERO);
        add_row(ROW_WRITE,  asb_pkg::REG_POLARITY, 16'h0001, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_POLARITY, 16'hFFFE, EXP_MODEL);
        add_row(ROW_WRITE,  REG_UNUSED,            16'h1234, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_DECAY,    16'hFFFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_DECAY,    16'h0000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0001, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'hFFFF, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_STEP,     16'h0001, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h1234, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h8000, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_STEP,     16'h0000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0000, EXP_MODEL);
        add_row(ROW_WRITE,  asb_pkg::REG_DECAY,    16'h8001, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h5555, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'hAAAA, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h0000, EXP_MODEL);
        add_row(ROW_SAMPLE, asb_pkg::REG_DECAY,    16'h7FFF, EXP_MODEL);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_register(directed_rows[i].idx, directed_rows[i].value);
            else
                send_sample(directed_rows[i].value, directed_rows[i].want);
        end

        // random part: tone-like symbol runs with noise, some raw full-range samples
        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: step_pick = 16'h0000;
                1: step_pick = 16'h0001;
                2: step_pick = 16'hFFFF;
                3: step_pick = 16'h8000;
                default: step_pick = 16'($urandom_range(1500, 20000));
            endcase
            case ($urandom_range(0, 7))
                0: decay_pick = 16'h0000;
                1: decay_pick = 16'h0001;
                2: decay_pick = 16'hFFFF;
                3: decay_pick = 16'h8000;
                default: decay_pick = 16'($urandom_range(16, 4000));
            endcase
            // first phase: almost every sample wraps the clock and the receiver holds off
            if (phase_no == 0)
                step_pick = 16'hFFFF;
            write_register(asb_pkg::REG_STEP, step_pick);
            write_register(asb_pkg::REG_DECAY, decay_pick);
            write_register(asb_pkg::REG_POLARITY, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_UNUSED, 16'($urandom_range(0, 65535)));

            tx_quiet = (phase_no == 0) || ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase_no == 0)
                rx_hold_req = 1'b1;

            spb = (step_pick == 0) ? 16 : 65536 / step_pick;
            if (spb > 40)
                spb = 40;
            if (spb < 1)
                spb = 1;
            amp = int'($urandom_range(200, 32767));
            bias = int'($urandom_range(0, 16000)) - 8000;
            run_left = 0;
            level = 0;
            phase_len = $urandom_range(60, 180);

            for (n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    value = int'($urandom_range(0, 65535)) - 32768;
                else
                begin
                    if (run_left == 0)
                    begin
                        level = $urandom_range(0, 1) ? amp : -amp;
                        run_left = spb * int'($urandom_range(1, 3))
                                   + int'($urandom_range(0, 2)) - 1;
                        if (run_left < 1)
                            run_left = 1;
                    end
                    value = bias + level + int'($urandom_range(0, amp / 4)) - amp / 8;
                    run_left--;
                end
                if (value > 32767)
                    value = 32767;
                if (value < -32768)
                    value = -32768;
                send_sample(value[15:0], EXP_MODEL);
            end
            random_sent += phase_len;
            phase_no++;
        end

        // drain
        smp_if.valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && expected_bits.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_bits.size() != 0)
            report_mismatch($sformatf("%0d expected bits never came", expected_bits.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
design/asb_pkg.sv
design/asb_sample_if.sv
design/asb_bit_if.sv
design/asb_peak_track.sv
design/asb_bit_clock.sv
design/afsk_slicer_bit_clock_core.sv
design/asb_checker.sv
bench/afsk_slicer_bit_clock_core_test.sv
